/* hw/rtl/buddy_block_allocator_top_macros.svh */
// ----------------------------------------------------------------------------
// buddy allocator assertion macros
// concurrent check helpers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define BBA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BBA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* hw/rtl/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// geometry, codes and helpers of the buddy block allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bba_pkg;

  localparam int POOL_BYTES      = 65536;
  localparam int MIN_BLOCK_BYTES = 64;

  localparam int POOL_LOG  = $clog2(POOL_BYTES);
  localparam int POOL_P2   = 1 << POOL_LOG;
  localparam int MIN_LOG   = $clog2(MIN_BLOCK_BYTES);
  localparam int LEVELS    = (POOL_LOG >= MIN_LOG) ? POOL_LOG - MIN_LOG + 1 : 1;
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CNT_W     = LEVELS;
  localparam int ENT_DEPTH = (1 << LEVELS) - 1;
  localparam int ENT_AW    = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;
  localparam int GRAN_LOG  = POOL_LOG - (LEVELS - 1);
  localparam int GRANS     = 1 << (LEVELS - 1);
  localparam int GRAN_AW   = (LEVELS > 1) ? LEVELS - 1 : 1;
  localparam int MARK_W    = $clog2(LEVELS + 1);

  localparam int OFF_W  = 16;
  localparam int SIZE_W = 17;
  localparam int LOG_W  = 5;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOMEM   = 2'd1;
  localparam logic [1:0] STAT_BADFREE = 2'd2;

  function automatic logic [SIZE_W-1:0] level_bytes(input logic [LVL_W-1:0] l);
    return SIZE_W'(POOL_P2 >> l);
  endfunction

  function automatic logic [ENT_AW-1:0] entry_addr(input logic [LVL_W-1:0] l,
                                                   input logic [CNT_W-1:0] i);
    return ENT_AW'((32'd1 << l) - 32'd1 + 32'(i));
  endfunction

  // smallest e with 2^e >= v, v at least one
  function automatic logic [LOG_W-1:0] ceil_log2(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] m;
    logic [LOG_W-1:0]  r;
    m = v - SIZE_W'(1);
    r = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (m[i]) r = LOG_W'(i + 1);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/bba_req_if.sv */
// ----------------------------------------------------------------------------
// bba_req_if
// request channel: command and its operands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bba_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [16:0] request_size;
  logic [15:0] free_offset;

  modport source (output valid, command, request_size, free_offset, input ready);
  modport sink   (input valid, command, request_size, free_offset, output ready);
endinterface

/* hw/rtl/bba_rsp_if.sv */
// ----------------------------------------------------------------------------
// bba_rsp_if
// result channel: status, block and pool occupancy
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bba_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] block_offset;
  logic [16:0] block_bytes;
  logic [16:0] used_bytes;
  logic [16:0] largest_free_bytes;

  modport source (output valid, status, block_offset, block_bytes, used_bytes,
                  largest_free_bytes, input ready);
  modport sink   (input valid, status, block_offset, block_bytes, used_bytes,
                  largest_free_bytes, output ready);
endinterface

/* hw/rtl/buddy_block_allocator_top.sv */
// ----------------------------------------------------------------------------
// buddy_block_allocator_top
// buddy allocator with per-level lifo free lists kept in one memory
// ----------------------------------------------------------------------------
// usage:
//   req carries one item: allocate (request_size) or free (free_offset).
//   rsp returns one item per request: status, block offset and size, bytes in
//   use and the largest free block size.
//   after rst the allocation marks of all 1024 granules are cleared, one
//   granule a cycle; req.ready stays low until that pass ends.
//   one request is worked at a time. an allocate pops the smallest free block
//   that fits and splits it down one level at a time; a free checks the mark,
//   then per merge level scans the free list for the buddy, moves the entries
//   after the removed buddy up and goes one level up. the free list memory
//   has a single port, so one entry is read or written at a time. a free of a
//   bad offset or of a block not in use returns the bad free status.
//   the result sits in an output register; while rsp is stalled the block
//   still takes the next request and holds its result until rsp frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "buddy_block_allocator_top_macros.svh"

module buddy_block_allocator_top (
  input logic    clk,
  input logic    rst,
  bba_req_if.sink   req,
  bba_rsp_if.source rsp
);
  import bba_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CALC, S_POP_RD, S_POP, S_SPLIT, S_FREE_RD, S_FREE_CHK,
    S_MERGE, S_SCAN_RD, S_SCAN_CMP, S_SH_RD, S_SH_WR, S_DONE
  } state_t;

  state_t state;

  logic [GRAN_AW-1:0] clr_idx;
  logic [SIZE_W-1:0]  req_size;
  logic [OFF_W-1:0]   off;
  logic [LVL_W-1:0]   lvl;
  logic [LVL_W-1:0]   sj;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   cnt [LEVELS];
  logic [SIZE_W-1:0]  used;
  logic [1:0]         stat;
  logic [OFF_W-1:0]   res_off;
  logic [SIZE_W-1:0]  res_bytes;

  // free list memory
  logic [OFF_W-1:0]  ent_mem [ENT_DEPTH];
  logic              ent_we, ent_re;
  logic [ENT_AW-1:0] ent_addr;
  logic [OFF_W-1:0]  ent_wdata, ent_q;

  // allocation marks, level plus one per granule
  logic [MARK_W-1:0]  mark_mem [GRANS];
  logic               mark_we, mark_re;
  logic [GRAN_AW-1:0] mark_addr;
  logic [MARK_W-1:0]  mark_wdata, mark_q;

  logic [SIZE_W-1:0] sz_min;
  logic [LOG_W-1:0]  req_log;
  logic [LVL_W-1:0]  want_lvl;
  logic [LVL_W-1:0]  src_lvl;
  logic              src_found;
  logic [OFF_W-1:0]  buddy;
  logic [OFF_W-1:0]  lvl_mask;
  logic [CNT_W:0]    idx_inc;
  logic              more;
  logic              match;
  logic [SIZE_W-1:0] largest;
  logic [GRAN_AW-1:0] off_gran;
  logic              off_bad;
  logic [LVL_W-1:0]  sj_up;

  always_comb begin
    sz_min   = (req_size < SIZE_W'(MIN_BLOCK_BYTES)) ? SIZE_W'(MIN_BLOCK_BYTES) : req_size;
    req_log  = ceil_log2(sz_min);
    if (32'(POOL_LOG) - 32'(req_log) > 32'(LEVELS - 1)) begin
      want_lvl = LVL_W'(LEVELS - 1);
    end else begin
      want_lvl = LVL_W'(32'(POOL_LOG) - 32'(req_log));
    end
    src_found = 1'b0;
    src_lvl   = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (LVL_W'(i) <= want_lvl && cnt[i] != '0) begin
        src_found = 1'b1;
        src_lvl   = LVL_W'(i);
      end
    end
    largest = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (cnt[i] != '0) largest = level_bytes(LVL_W'(i));
    end
    lvl_mask = OFF_W'(level_bytes(lvl));
    buddy    = off ^ lvl_mask;
    idx_inc  = {1'b0, idx} + (CNT_W+1)'(1);
    more     = idx_inc < {1'b0, cnt[lvl]};
    match    = ent_q == buddy;
    off_gran = GRAN_AW'(off >> GRAN_LOG);
    off_bad  = (32'(off) >= POOL_P2) || ((32'(off) & ((1 << GRAN_LOG) - 1)) != 0);
    sj_up    = sj + LVL_W'(1);
  end

  // memory port control
  always_comb begin
    ent_we     = 1'b0;
    ent_re     = 1'b0;
    ent_addr   = '0;
    ent_wdata  = off;
    mark_we    = 1'b0;
    mark_re    = 1'b0;
    mark_addr  = off_gran;
    mark_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        mark_we   = 1'b1;
        mark_addr = clr_idx;
        ent_we    = (clr_idx == '0);
        ent_wdata = '0;
      end
      S_POP_RD: begin
        ent_re   = 1'b1;
        ent_addr = entry_addr(sj, cnt[sj] - CNT_W'(1));
      end
      S_POP: begin
        mark_we    = 1'b1;
        mark_addr  = GRAN_AW'(ent_q >> GRAN_LOG);
        mark_wdata = MARK_W'(lvl) + MARK_W'(1);
      end
      S_SPLIT: begin
        ent_we    = 1'b1;
        ent_addr  = entry_addr(sj_up, cnt[sj_up]);
        ent_wdata = off + OFF_W'(level_bytes(sj_up));
      end
      S_FREE_RD: mark_re = !off_bad;
      S_FREE_CHK: mark_we = (mark_q != '0);
      S_MERGE: begin
        ent_we   = (lvl == '0) || (cnt[lvl] == '0);
        ent_addr = entry_addr(lvl, cnt[lvl]);
      end
      S_SCAN_RD, S_SH_RD: begin
        ent_re   = 1'b1;
        ent_addr = entry_addr(lvl, idx);
      end
      S_SCAN_CMP: begin
        ent_we   = !match && !more;
        ent_addr = entry_addr(lvl, cnt[lvl]);
      end
      S_SH_WR: begin
        ent_we    = 1'b1;
        ent_addr  = entry_addr(lvl, idx - CNT_W'(1));
        ent_wdata = ent_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_addr] <= ent_wdata;
    if (ent_re) ent_q <= ent_mem[ent_addr];
  end

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_addr] <= mark_wdata;
    if (mark_re) mark_q <= mark_mem[mark_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      used      <= '0;
      rsp.valid <= 1'b0;
      for (int i = 0; i < LEVELS; i++) cnt[i] <= (i == 0) ? CNT_W'(1) : '0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_DONE) rsp.valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + GRAN_AW'(1);
          if (clr_idx == GRAN_AW'(GRANS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid) begin
            req_size  <= req.request_size;
            off       <= req.free_offset;
            res_off   <= '0;
            res_bytes <= '0;
            state     <= (req.command == CMD_ALLOC) ? S_CALC : S_FREE_RD;
          end
        end
        S_CALC: begin
          lvl <= want_lvl;
          sj  <= src_lvl;
          if (32'(req_log) > POOL_LOG || !src_found) begin
            stat  <= STAT_NOMEM;
            state <= S_DONE;
          end else begin
            state <= S_POP_RD;
          end
        end
        S_POP_RD: state <= S_POP;
        S_POP: begin
          off       <= ent_q;
          res_off   <= ent_q;
          res_bytes <= level_bytes(lvl);
          used      <= used + level_bytes(lvl);
          stat      <= STAT_OK;
          cnt[sj]   <= cnt[sj] - CNT_W'(1);
          state     <= (sj == lvl) ? S_DONE : S_SPLIT;
        end
        S_SPLIT: begin
          cnt[sj_up] <= cnt[sj_up] + CNT_W'(1);
          sj         <= sj_up;
          if (sj_up == lvl) state <= S_DONE;
        end
        S_FREE_RD: begin
          if (off_bad) begin
            stat  <= STAT_BADFREE;
            state <= S_DONE;
          end else begin
            state <= S_FREE_CHK;
          end
        end
        S_FREE_CHK: begin
          if (mark_q == '0) begin
            stat  <= STAT_BADFREE;
            state <= S_DONE;
          end else begin
            lvl       <= LVL_W'(mark_q - MARK_W'(1));
            res_bytes <= level_bytes(LVL_W'(mark_q - MARK_W'(1)));
            used      <= used - level_bytes(LVL_W'(mark_q - MARK_W'(1)));
            stat      <= STAT_OK;
            state     <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (lvl == '0 || cnt[lvl] == '0) begin
            cnt[lvl] <= cnt[lvl] + CNT_W'(1);
            state    <= S_DONE;
          end else begin
            idx   <= '0;
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: state <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (match) begin
            if (more) begin
              idx   <= idx_inc[CNT_W-1:0];
              state <= S_SH_RD;
            end else begin
              // buddy was last: drop it and go one level up
              cnt[lvl] <= cnt[lvl] - CNT_W'(1);
              off      <= off & ~lvl_mask;
              lvl      <= lvl - LVL_W'(1);
              state    <= S_MERGE;
            end
          end else if (more) begin
            idx   <= idx_inc[CNT_W-1:0];
            state <= S_SCAN_RD;
          end else begin
            cnt[lvl] <= cnt[lvl] + CNT_W'(1);
            state    <= S_DONE;
          end
        end
        S_SH_RD: state <= S_SH_WR;
        S_SH_WR: begin
          if (more) begin
            idx   <= idx_inc[CNT_W-1:0];
            state <= S_SH_RD;
          end else begin
            cnt[lvl] <= cnt[lvl] - CNT_W'(1);
            off      <= off & ~lvl_mask;
            lvl      <= lvl - LVL_W'(1);
            state    <= S_MERGE;
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid              <= 1'b1;
            rsp.status             <= stat;
            rsp.block_offset       <= res_off;
            rsp.block_bytes        <= res_bytes;
            rsp.used_bytes         <= used;
            rsp.largest_free_bytes <= largest;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);

  `BBA_ASSERT_IMPLY(a_no_take_in_clear, clk, rst, state == S_CLEAR, !req.ready, "item taken during mark clear")
  `BBA_ASSERT_NEXT(a_one_at_a_time, clk, rst, req.valid && req.ready, !req.ready, "second item taken while busy")
  `BBA_ASSERT_IMPLY(a_top_level_cap, clk, rst, 1'b1, cnt[0] <= CNT_W'(1), "top level holds more than the pool")
  `BBA_ASSERT_IMPLY(a_used_cap, clk, rst, 1'b1, 32'(used) <= POOL_P2, "bytes in use exceed the pool")

endmodule
